// ===== hdl/paged_memory_frame_manager_assert.svh =====
// Assertion macros for the paged memory frame manager.
`ifndef PAGED_MEMORY_FRAME_MANAGER_ASSERT_SVH
`define PAGED_MEMORY_FRAME_MANAGER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PMFM_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define PMFM_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hdl/pmfm_pkg.sv =====
// Package for the paged memory frame manager: codes, widths, state type.
package pmfm_pkg;
    localparam int DEF_MAX_PROCS  = 16;
    localparam int DEF_MAX_PAGES  = 64;
    localparam int DEF_NUM_FRAMES = 256;
    localparam int PS_W    = 13;
    localparam int BYTES_W = 16;
    localparam int PS_RESET = 32;

    typedef enum logic [1:0] {
        OP_CREATE    = 2'd0,
        OP_RESIZE    = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_TERMINATE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_TABLE = 3'd1,
        ST_OOM      = 3'd2,
        ST_RANGE    = 3'd3,
        ST_EXISTS   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_GROW_SCAN,
        S_SHRINK_RD,
        S_SHRINK_WAIT,
        S_SHRINK_FREE,
        S_XLATE_WAIT,
        S_DONE
    } state_t;
endpackage

// ===== hdl/paged_memory_frame_manager.sv =====
// Top level of the paged memory frame manager: page tables and frame bitmap.
//
//  channel | dir | handshake          | content
//  s_      | in  | s_tvalid/s_tready  | op, pid, size_bytes, page
//  m_      | out | m_tvalid/m_tready  | status, frame, page_count
//  cfg     | in  | cfg_valid/cfg_ready| page_size
//
// One request at a time. Create goes straight to the result; translate reads the page table first.
// Resize: a restoring divider, then per new page a bitmap scan from the lowest
// frame, and per dropped page a table read (S_SHRINK_RD, S_SHRINK_WAIT, S_SHRINK_FREE).
// Terminate: the same shrink loop for every held page. After reset a pass
// clears the frame bitmap memory; no request is taken during it.
// The result register holds until m_tready; s_tready is low while busy.
module paged_memory_frame_manager
    import pmfm_pkg::*;
#(
    parameter int MAX_PROCS  = DEF_MAX_PROCS,
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // op[1:0], pid[5:2], size_bytes[21:6], page[27:22]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[2:0], frame[10:3], page_count[17:11]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // page_size[12:0]
);
    `include "paged_memory_frame_manager_assert.svh"

    localparam int PR_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int FR_W  = $clog2(NUM_FRAMES);
    localparam int FC_W  = $clog2(NUM_FRAMES + 1);
    localparam int TA_W  = PR_W + PG_W;

    // Input fields
    logic [1:0]         in_op;
    logic [3:0]         in_pid;
    logic [BYTES_W-1:0] in_bytes;
    logic [5:0]         in_page;
    assign in_op    = s_tdata[1:0];
    assign in_pid   = s_tdata[5:2];
    assign in_bytes = s_tdata[21:6];
    assign in_page  = s_tdata[27:22];

    logic [PS_W-1:0] page_size_reg;

    // Memories
    logic [FR_W-1:0] table_mem [MAX_PROCS*MAX_PAGES];
    logic            busy_mem  [NUM_FRAMES];
    logic            tbl_we;
    logic [TA_W-1:0] tbl_waddr, tbl_raddr;
    logic [FR_W-1:0] tbl_wdata, tbl_rdata_reg;
    logic            bm_we;
    logic [FR_W-1:0] bm_waddr, bm_raddr;
    logic            bm_wdata, bm_rdata_reg;

    always_ff @(posedge aclk) begin
        if (tbl_we) table_mem[tbl_waddr] <= tbl_wdata;
        tbl_rdata_reg <= table_mem[tbl_raddr];
    end
    always_ff @(posedge aclk) begin
        if (bm_we) busy_mem[bm_waddr] <= bm_wdata;
        bm_rdata_reg <= busy_mem[bm_raddr];
    end

    // Per-process small state
    logic [CNT_W-1:0] held_reg [MAX_PROCS];
    logic [MAX_PROCS-1:0] present_reg;

    state_t state_reg, state_next;
    logic [1:0]         op_reg;
    logic [PR_W-1:0]    pid_reg;
    logic [5:0]         page_reg;
    logic [CNT_W-1:0]   have_reg, have_next;
    logic [BYTES_W:0]   want_reg, want_next;     // quotient, may exceed MAX_PAGES
    logic [FC_W-1:0]    scan_reg, scan_next;     // bitmap scan / clear position
    logic [2:0]         res_status_reg, res_status_next;
    logic [7:0]         res_frame_reg, res_frame_next;
    logic [6:0]         res_count_reg, res_count_next;
    logic               m_valid_reg, m_valid_next;
    // Divider
    logic [BYTES_W:0]   dividend_reg, dividend_next;
    logic [PS_W:0]      rem_reg, rem_next;
    logic [4:0]         dcnt_reg, dcnt_next;
    logic               scan_pend_reg, scan_pend_next;

    logic [PS_W-1:0] ps_eff;
    logic [PS_W:0]   rem_sh;
    logic            pid_ok;
    logic [PR_W-1:0] pid_cut;
    logic [TA_W-1:0] base_addr;
    logic            held_we, pres_set, pres_clr;
    logic [CNT_W-1:0] held_wdata;

    assign ps_eff   = (page_size_reg == '0) ? PS_W'(1) : page_size_reg;
    assign pid_cut  = PR_W'(in_pid);
    assign pid_ok   = (32'(in_pid) < MAX_PROCS);
    assign base_addr = {pid_reg, PG_W'(0)};
    assign rem_sh   = {rem_reg[PS_W-1:0], dividend_reg[BYTES_W]};

    assign s_tready  = (state_reg == S_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, res_count_reg, res_frame_reg, res_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_size_reg <= PS_W'(PS_RESET);
        end else if (cfg_valid) begin
            page_size_reg <= cfg_data[PS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
            present_reg <= '0;
            scan_reg    <= '0;
            for (int i = 0; i < MAX_PROCS; i++) held_reg[i] <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            scan_reg    <= scan_next;
            if (held_we) held_reg[pid_reg] <= held_wdata;
            if (pres_set) present_reg[pid_reg] <= 1'b1;
            if (pres_clr) present_reg[pid_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= in_op;
            pid_reg  <= pid_cut;
            page_reg <= in_page;
        end
        have_reg       <= have_next;
        want_reg       <= want_next;
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        res_count_reg  <= res_count_next;
        dividend_reg   <= dividend_next;
        rem_reg        <= rem_next;
        dcnt_reg       <= dcnt_next;
        scan_pend_reg  <= scan_pend_next;
    end

    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        have_next       = have_reg;
        want_next       = want_reg;
        scan_next       = scan_reg;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        res_count_next  = res_count_reg;
        dividend_next   = dividend_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        scan_pend_next  = 1'b0;
        tbl_we    = 1'b0;
        tbl_waddr = base_addr + TA_W'(have_reg);
        tbl_wdata = scan_reg[FR_W-1:0];
        tbl_raddr = base_addr + TA_W'(have_reg);
        bm_we     = 1'b0;
        bm_waddr  = scan_reg[FR_W-1:0];
        bm_wdata  = 1'b0;
        bm_raddr  = scan_reg[FR_W-1:0];
        held_we   = 1'b0;
        held_wdata = have_reg;
        pres_set  = 1'b0;
        pres_clr  = 1'b0;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                bm_we = 1'b1;
                scan_next = scan_reg + FC_W'(1);
                if (scan_reg == FC_W'(NUM_FRAMES - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    res_status_next = ST_OK;
                    res_frame_next  = '0;
                    res_count_next  = '0;
                    have_next       = held_reg[pid_cut];
                    dividend_next   = {1'b0, in_bytes} + {1'b0, BYTES_W'(ps_eff)}
                                      - (BYTES_W+1)'(1);
                    rem_next        = '0;
                    dcnt_next       = '0;
                    if (!pid_ok) begin
                        res_status_next = ST_NO_TABLE;
                        state_next = S_DONE;
                    end else if (op_t'(in_op) == OP_CREATE) begin
                        if (present_reg[pid_cut]) begin
                            res_status_next = ST_EXISTS;
                            res_count_next  = 7'(held_reg[pid_cut]);
                        end
                        state_next = S_DONE;
                    end else if (!present_reg[pid_cut]) begin
                        res_status_next = ST_NO_TABLE;
                        state_next = S_DONE;
                    end else begin
                        case (op_t'(in_op))
                            OP_RESIZE:    state_next = S_DIV;
                            OP_TRANSLATE: state_next = S_XLATE_WAIT;
                            default: begin
                                want_next  = '0;
                                state_next = S_SHRINK_RD;
                            end
                        endcase
                        if (op_t'(in_op) == OP_TRANSLATE) begin
                            tbl_raddr = {pid_cut, PG_W'(in_page)};
                        end
                    end
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                // (ceil is folded into the dividend; carry bit included)
                if (rem_sh >= {1'b0, ps_eff}) begin
                    rem_next = rem_sh - {1'b0, ps_eff};
                    dividend_next = {dividend_reg[BYTES_W-1:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    dividend_next = {dividend_reg[BYTES_W-1:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'(BYTES_W)) begin
                    want_next = dividend_next;
                    scan_next = '0;
                    scan_pend_next = 1'b1;
                    if ({{(BYTES_W+1-CNT_W){1'b0}}, have_reg} < dividend_next) begin
                        state_next = S_GROW_SCAN;
                    end else begin
                        state_next = S_SHRINK_RD;
                    end
                end
            end
            S_GROW_SCAN: begin
                // scan_reg addresses the bitmap; the registered data arrives in the next cycle
                if ({{(BYTES_W+1-CNT_W){1'b0}}, have_reg} >= want_reg) begin
                    held_we = 1'b1;
                    res_count_next = 7'(have_reg);
                    state_next = S_DONE;
                end else if (have_reg == CNT_W'(MAX_PAGES)) begin
                    held_we = 1'b1;
                    res_status_next = ST_OOM;
                    res_count_next = 7'(have_reg);
                    state_next = S_DONE;
                end else if (scan_pend_reg) begin
                    scan_next = scan_reg;
                end else if (!bm_rdata_reg) begin
                    bm_we = 1'b1;
                    bm_waddr = FR_W'(scan_reg - FC_W'(1));
                    bm_wdata = 1'b1;
                    tbl_we = 1'b1;
                    tbl_wdata = FR_W'(scan_reg - FC_W'(1));
                    have_next = have_reg + CNT_W'(1);
                    scan_next = '0;
                    scan_pend_next = 1'b1;
                end else if (scan_reg == FC_W'(NUM_FRAMES)) begin
                    held_we = 1'b1;
                    res_status_next = ST_OOM;
                    res_count_next = 7'(have_reg);
                    state_next = S_DONE;
                end
                if (state_next == S_GROW_SCAN && !(!scan_pend_reg && !bm_rdata_reg)) begin
                    if (!scan_pend_reg) scan_next = scan_reg + FC_W'(1);
                    else scan_next = scan_reg + FC_W'(1);
                    bm_raddr = scan_reg[FR_W-1:0];
                end
            end
            S_SHRINK_RD: begin
                if ({{(BYTES_W+1-CNT_W){1'b0}}, have_reg} <= want_reg) begin
                    held_we = 1'b1;
                    res_count_next = 7'(have_reg);
                    if (op_t'(op_reg) == OP_TERMINATE) begin
                        held_wdata = '0;
                        pres_clr = 1'b1;
                        res_count_next = '0;
                    end
                    state_next = S_DONE;
                end else begin
                    have_next = have_reg - CNT_W'(1);
                    tbl_raddr = base_addr + TA_W'(have_reg - CNT_W'(1));
                    state_next = S_SHRINK_WAIT;
                end
            end
            S_SHRINK_WAIT: state_next = S_SHRINK_FREE;
            S_SHRINK_FREE: begin
                bm_we = 1'b1;
                bm_waddr = tbl_rdata_reg;
                bm_wdata = 1'b0;
                state_next = S_SHRINK_RD;
            end
            S_XLATE_WAIT: begin
                if (7'(page_reg) < 7'(have_reg)) res_frame_next = 8'(tbl_rdata_reg);
                else res_status_next = ST_RANGE;
                res_count_next = 7'(have_reg);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (op_t'(op_reg) == OP_CREATE && res_status_reg == ST_OK) begin
                    pres_set = 1'b1;
                    held_we = 1'b1;
                    held_wdata = '0;
                end
                m_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `PMFM_ASSERT_IMP(a_busy_no_accept, aclk, aresetn, state_reg != S_IDLE, !s_tready)
    `PMFM_ASSERT_NEXT(a_done_valid, aclk, aresetn, state_reg == S_DONE, m_valid_reg)
    `PMFM_ASSERT_IMP(a_status_range, aclk, aresetn, m_valid_reg,
        res_status_reg == ST_OK || res_status_reg == ST_NO_TABLE ||
        res_status_reg == ST_OOM || res_status_reg == ST_RANGE ||
        res_status_reg == ST_EXISTS)
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the paged memory frame manager.
`timescale 1ns / 100ps

module tb_top
    import pmfm_pkg::*;
();

    localparam int NPROC       = 16;
    localparam int NPAGE       = 64;
    localparam int NFRAME      = 256;
    localparam int CYCLE_LIMIT = 60000000;
    localparam int DRAIN_WAIT  = 300;

    typedef struct packed {
        status_t    status;
        logic [7:0] frame;
        logic [6:0] count;
    } reply_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // op[1:0], pid[5:2], size_bytes[21:6], page[27:22]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // status[2:0], frame[10:3], page_count[17:11]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;  // page_size[12:0]

    paged_memory_frame_manager dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // shadow copy of the page tables and frame bitmap
    logic [12:0] page_size_q;
    logic [7:0]  page_frame [NPROC][NPAGE];
    int          pages_held [NPROC];
    bit          proc_live  [NPROC];
    bit          frame_used [NFRAME];

    logic [31:0] request_q[$];
    reply_t      expected_replies[$];
    int          errors;
    int          cyc;
    int          n_accepted;
    int          hold_left;
    bit          hold_done;
    bit          s_fire;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cyc);
        errors++;
    endtask

    // Applies one accepted request to the shadow state and queues its reply.
    function automatic void page_table_step(input logic [31:0] d);
        op_t         op;
        int          pid, bytes, page, ps, target, have, f;
        reply_t      r;
        op    = op_t'(d[1:0]);
        pid   = d[5:2];
        bytes = d[21:6];
        page  = d[27:22];
        r.status = ST_OK;
        r.frame  = '0;
        r.count  = '0;
        if (op == OP_CREATE) begin
            if (proc_live[pid]) begin
                r.status = ST_EXISTS;
                r.count  = 7'(pages_held[pid]);
            end else begin
                proc_live[pid]  = 1'b1;
                pages_held[pid] = 0;
            end
        end else if (!proc_live[pid]) begin
            r.status = ST_NO_TABLE;
        end else if (op == OP_RESIZE) begin
            ps     = (page_size_q == 0) ? 1 : page_size_q;
            target = (bytes + ps - 1) / ps;
            have   = pages_held[pid];
            while (have < target) begin
                f = 0;
                while (f < NFRAME && frame_used[f]) f++;
                if (have >= NPAGE || f == NFRAME) begin
                    r.status = ST_OOM;
                    break;
                end
                frame_used[f] = 1'b1;
                page_frame[pid][have] = 8'(f);
                have++;
            end
            while (have > target) begin
                have--;
                frame_used[page_frame[pid][have]] = 1'b0;
            end
            pages_held[pid] = have;
            r.count = 7'(have);
        end else if (op == OP_TRANSLATE) begin
            r.count = 7'(pages_held[pid]);
            if (page < pages_held[pid]) r.frame = page_frame[pid][page];
            else r.status = ST_RANGE;
        end else begin
            for (int i = 0; i < pages_held[pid]; i++) frame_used[page_frame[pid][i]] = 1'b0;
            pages_held[pid] = 0;
            proc_live[pid]  = 1'b0;
        end
        expected_replies.push_back(r);
    endfunction

    function automatic void push_req(input op_t op, input int pid, input int bytes,
                                     input int page);
        request_q.push_back({4'b0, page[5:0], bytes[15:0], pid[3:0], op});
    endfunction

    // Mostly sizes of up to 20 pages; now and then anything.
    function automatic void push_random(input int ps);
        int r, lim;
        r   = $urandom_range(0, 99);
        lim = ps * 20;
        if (lim > 65535) lim = 65535;
        if (r < 15)
            push_req(OP_CREATE, $urandom_range(0, 15), $urandom_range(0, 65535),
                     $urandom_range(0, 63));
        else if (r < 55)
            push_req(OP_RESIZE, $urandom_range(0, 15),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, lim),
                     $urandom_range(0, 63));
        else if (r < 90)
            push_req(OP_TRANSLATE, $urandom_range(0, 15), $urandom_range(0, 65535),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 20));
        else
            push_req(OP_TERMINATE, $urandom_range(0, 15), $urandom_range(0, 65535),
                     $urandom_range(0, 63));
    endfunction

    function automatic bit idle_now();
        if (n_accepted >= 900 && n_accepted < 1300) return 1'b0;
        return $urandom_range(0, 99) < 12;
    endfunction

    task automatic wait_drained();
        while (request_q.size() != 0 || expected_replies.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    task automatic write_page_size(input logic [12:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= {3'($urandom_range(0, 7)), v};
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (request_q.size() != 0 && !idle_now()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= request_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready, with one long hold-off so the block backs up
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (n_accepted >= 700 && !hold_done) begin
                m_tready  <= 1'b0;
                hold_left <= 400;
                hold_done <= 1'b1;
            end else begin
                m_tready <= !idle_now();
            end
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        reply_t want;
        cyc <= cyc + 1;
        s_fire <= s_tvalid && s_tready;
        if (cfg_valid && cfg_ready) page_size_q = cfg_data[12:0];
        if (s_tvalid && s_tready) begin
            page_table_step(s_tdata);
            n_accepted <= n_accepted + 1;
        end
        if (m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected result", int'(m_tdata), 0);
            end else begin
                want = expected_replies.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch("status", m_tdata[2:0], want.status);
                if (m_tdata[10:3] !== want.frame)
                    report_mismatch("frame", m_tdata[10:3], want.frame);
                if (m_tdata[17:11] !== want.count)
                    report_mismatch("page_count", m_tdata[17:11], want.count);
            end
        end
        if (cyc > CYCLE_LIMIT) begin
            $display("FAIL paged_memory_frame_manager");
            $finish;
        end
    end

    initial begin
        logic [12:0] sizes[7];
        errors = 0; cyc = 0; n_accepted = 0; hold_left = 0; hold_done = 0; s_fire = 0;
        page_size_q = 13'(PS_RESET);
        foreach (pages_held[i]) begin
            pages_held[i] = 0;
            proc_live[i]  = 1'b0;
        end
        foreach (frame_used[i]) frame_used[i] = 1'b0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_page_size(13'd32);
        // directed: every op, unknown pid, duplicate create, running out of frames
        push_req(OP_TRANSLATE, 5, 0, 0);
        push_req(OP_RESIZE, 5, 100, 0);
        push_req(OP_TERMINATE, 5, 0, 0);
        push_req(OP_CREATE, 0, 0, 0);
        push_req(OP_CREATE, 0, 0, 0);
        push_req(OP_RESIZE, 0, 0, 0);
        push_req(OP_RESIZE, 0, 65535, 0);      // beyond the table size
        push_req(OP_TRANSLATE, 0, 0, 63);
        push_req(OP_TRANSLATE, 0, 0, 0);
        for (int p = 1; p < 4; p++) begin
            push_req(OP_CREATE, p, 0, 0);
            push_req(OP_RESIZE, p, 65535, 0);
        end
        push_req(OP_CREATE, 15, 0, 0);
        push_req(OP_RESIZE, 15, 1, 0);         // no frame left
        push_req(OP_TRANSLATE, 15, 0, 0);
        push_req(OP_RESIZE, 0, 100, 0);        // shrink frees from the top
        push_req(OP_RESIZE, 15, 65535, 0);     // partial grow then out of frames
        push_req(OP_TERMINATE, 1, 0, 0);
        push_req(OP_TERMINATE, 15, 0, 0);
        push_req(OP_TRANSLATE, 15, 0, 0);
        wait_drained();

        sizes = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd32, 13'd100, 13'd0};
        sizes[6] = 13'($urandom_range(1, 4096));
        foreach (sizes[k]) begin
            write_page_size(sizes[k]);
            for (int n = 0; n < 275; n++)
                push_random((sizes[k] == 0) ? 1 : sizes[k]);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("PASS paged_memory_frame_manager");
        else
            $display("FAIL paged_memory_frame_manager");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/pmfm_pkg.sv
hdl/paged_memory_frame_manager.sv
dv/tb_top.sv
